[src/rs_pkg.sv]
// Shared types and constants for the reservoir sampler.
// Holds the transaction payload structs and default sizes; no dependencies.
package rs_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int RESULT_LIMIT  = 16;
    localparam int SIZE_W        = 5;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;

    localparam logic ACT_OFFER = 1'b0;
    localparam logic ACT_FLUSH = 1'b1;

    typedef struct packed {
        logic               action;
        logic signed [31:0] item_value;
        logic        [31:0] random_word;
    } rs_in_t;

    typedef struct packed {
        logic signed [31:0] sample_value;
        logic        [3:0]  slot_index;
        logic               run_last;
        logic               reservoir_empty;
        logic        [31:0] total_seen;
    } rs_out_t;

endpackage

[src/rs_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module rs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[src/rs_mod_unit.sv]
// Bit-serial restoring modulo unit: remainder of a 32-bit dividend by a 33-bit divisor.
// One quotient bit per cycle; depends on no package.
module rs_mod_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [32:0] divisor,
    output logic        done,
    output logic [31:0] remainder
);

    logic        busy_reg;
    logic        done_reg;
    logic [4:0]  cnt_reg;
    logic [31:0] dvd_reg;
    logic [32:0] dsr_reg;
    logic [31:0] rem_reg;
    logic [32:0] trial;
    logic [32:0] diff;
    logic [31:0] rem_next;

    always_comb
    begin
        trial = {rem_reg, dvd_reg[31]};
        diff  = trial - dsr_reg;
        if (trial >= dsr_reg)
        begin
            rem_next = diff[31:0];
        end
        else
        begin
            rem_next = trial[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[30:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

[src/reservoir_sampler.sv]
// Reservoir sampler: keeps a uniform random sample of the offered stream items.
// Offer while filling: written in S_WRITE. Offer after the reservoir is full: S_MOD waits for
// the 32-step serial modulo of the random word by the running count; S_WRITE if below the size.
// Flush: each reported slot waits in S_FL_READ for a free result register, then S_FL_LOAD.
// Reset clears the count and sets the size to 16; the sample memory is not cleared.
module reservoir_sampler #(
    parameter int RESERVOIR_DEPTH = rs_pkg::DEPTH_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  rs_pkg::rs_in_t      item,
    output logic                result_valid,
    input  logic                result_ready,
    output rs_pkg::rs_out_t     result,
    input  logic                cfg_we,
    input  logic [rs_pkg::SIZE_W-1:0] cfg_wdata
);

    import rs_pkg::*;

    localparam int AW       = (RESERVOIR_DEPTH > 1) ? $clog2(RESERVOIR_DEPTH) : 1;
    localparam int SLOT_MAX = (RESERVOIR_DEPTH < RESULT_LIMIT) ? RESERVOIR_DEPTH
                                                               : RESULT_LIMIT;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOD,
        S_WRITE,
        S_FL_READ,
        S_FL_LOAD
    } state_t;

    state_t            state_reg;
    logic [SIZE_W-1:0] size_reg;
    logic [31:0]       items_seen_reg;
    logic [31:0]       item_reg;
    logic [4:0]        slot_reg;
    logic [4:0]        filled_reg;
    logic [31:0]       total_reg;
    logic [3:0]        k_reg;
    logic              result_valid_reg;
    rs_out_t           result_reg;

    logic [4:0]  n_eff;
    logic        item_accept;
    logic        filling;
    logic        out_free;
    logic        last_slot;
    logic        mod_start;
    logic        mod_done;
    logic [31:0] mod_rem;
    logic [32:0] mod_divisor;
    logic        ram_we;
    logic [31:0] ram_rdata;

    always_comb
    begin
        if (size_reg == '0)
        begin
            n_eff = 5'd1;
        end
        else if (size_reg > 5'(SLOT_MAX))
        begin
            n_eff = 5'(SLOT_MAX);
        end
        else
        begin
            n_eff = size_reg;
        end
    end

    assign item_ready  = (state_reg == S_IDLE);
    assign item_accept = item_valid && item_ready;
    assign filling     = items_seen_reg < {27'd0, n_eff};
    assign out_free    = !result_valid_reg || result_ready;
    assign last_slot   = ({1'b0, k_reg} + 5'd1) == filled_reg;
    assign mod_start   = item_accept && (item.action == ACT_OFFER) && !filling;
    assign mod_divisor = {1'b0, items_seen_reg} + 33'd1;
    assign ram_we      = (state_reg == S_WRITE);

    rs_mod_unit u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (item.random_word),
        .divisor   (mod_divisor),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    rs_ram #(
        .WIDTH (32),
        .DEPTH (RESERVOIR_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (AW'(slot_reg)),
        .wdata (item_reg),
        .raddr (AW'(k_reg)),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            size_reg         <= SIZE_RESET;
            items_seen_reg   <= '0;
            result_valid_reg <= 1'b0;
            k_reg            <= '0;
            filled_reg       <= '0;
        end
        else
        begin
            if (result_valid_reg && result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                size_reg <= cfg_wdata;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (item_accept)
                    begin
                        if (item.action == ACT_OFFER)
                        begin
                            item_reg <= item.item_value;
                            slot_reg <= items_seen_reg[4:0];
                            if (items_seen_reg != 32'hFFFF_FFFF)
                            begin
                                items_seen_reg <= items_seen_reg + 32'd1;
                            end
                            state_reg <= filling ? S_WRITE : S_MOD;
                        end
                        else
                        begin
                            filled_reg     <= filling ? items_seen_reg[4:0] : n_eff;
                            total_reg      <= items_seen_reg;
                            items_seen_reg <= '0;
                            k_reg          <= '0;
                            state_reg      <= S_FL_READ;
                        end
                    end
                end
                S_MOD:
                begin
                    if (mod_done)
                    begin
                        if (mod_rem < {27'd0, n_eff})
                        begin
                            slot_reg  <= mod_rem[4:0];
                            state_reg <= S_WRITE;
                        end
                        else
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                S_WRITE:
                begin
                    state_reg <= S_IDLE;
                end
                S_FL_READ:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_FL_LOAD;
                    end
                end
                S_FL_LOAD:
                begin
                    result_valid_reg <= 1'b1;
                    if (filled_reg == '0)
                    begin
                        result_reg.sample_value    <= '0;
                        result_reg.slot_index      <= '0;
                        result_reg.run_last        <= 1'b1;
                        result_reg.reservoir_empty <= 1'b1;
                        result_reg.total_seen      <= '0;
                        state_reg                  <= S_IDLE;
                    end
                    else
                    begin
                        result_reg.sample_value    <= ram_rdata;
                        result_reg.slot_index      <= k_reg;
                        result_reg.run_last        <= last_slot;
                        result_reg.reservoir_empty <= 1'b0;
                        result_reg.total_seen      <= total_reg;
                        if (last_slot)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            k_reg     <= k_reg + 4'd1;
                            state_reg <= S_FL_READ;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // A slot is loaded only when the result register has been freed.
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FL_LOAD |-> !result_valid_reg)
        else $error("result register overwritten before it was taken");

    a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FL_LOAD |=> result_valid_reg)
        else $error("flush load did not present a result");

    a_mod_state: assert property (@(posedge clk) disable iff (!rst_n)
        mod_done |-> state_reg == S_MOD)
        else $error("modulo finished outside the draw state");

    a_write_slot: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> slot_reg < n_eff)
        else $error("sample write beyond the reservoir size");

    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && result_reg.reservoir_empty |-> result_reg.run_last)
        else $error("empty marker not flagged as last");

endmodule

[sim/reservoir_sampler_checker.sv]
`timescale 1ns / 1ps
// Scoreboard for the reservoir sampler. It watches the item, result and configuration ports,
// predicts every flush report and compares it field by field with each accepted result.
// Depends on rs_pkg for the transaction structs, the action codes and the size constants.
module reservoir_sampler_checker #(
    parameter int DEPTH = rs_pkg::DEPTH_DEFAULT
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      item_valid,
    input  logic                      item_ready,
    input  rs_pkg::rs_in_t            item,
    input  logic                      result_valid,
    input  logic                      result_ready,
    input  rs_pkg::rs_out_t           result,
    input  logic                      cfg_we,
    input  logic [rs_pkg::SIZE_W-1:0] cfg_wdata,
    output int                        fail_count,
    output int                        pending
);

    import rs_pkg::*;

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [31:0]       slot_mem [DEPTH];
    logic [31:0]       seen_count;
    logic [SIZE_W-1:0] size_reg;
    rs_out_t           report_queue [$];
    int                errors;

    function automatic int unsigned slots_in_use(input logic [SIZE_W-1:0] v);
        int unsigned n;
        n = 32'(v);
        if (n < 1)
            n = 1;
        if (n > DEPTH)
            n = DEPTH;
        if (n > RESULT_LIMIT)
            n = RESULT_LIMIT;
        return n;
    endfunction

    task automatic sample_or_flush(input rs_in_t t);
        int unsigned n;
        int unsigned filled;
        logic [63:0] pick;
        rs_out_t     rep;
        n = slots_in_use(size_reg);
        if (t.action == ACT_OFFER)
        begin
            if (seen_count < n)
                slot_mem[seen_count[IW-1:0]] = t.item_value;
            else
            begin
                pick = {32'd0, t.random_word} % ({32'd0, seen_count} + 64'd1);
                if (pick < 64'(n))
                    slot_mem[pick[IW-1:0]] = t.item_value;
            end
            if (seen_count != 32'hFFFF_FFFF)
                seen_count = seen_count + 32'd1;
        end
        else
        begin
            filled = (seen_count < n) ? seen_count : n;
            if (filled == 0)
            begin
                rep.sample_value    = '0;
                rep.slot_index      = '0;
                rep.run_last        = 1'b1;
                rep.reservoir_empty = 1'b1;
                rep.total_seen      = '0;
                report_queue        = {report_queue, rep};
            end
            for (int unsigned k = 0; k < filled; k++)
            begin
                rep.sample_value    = slot_mem[k[IW-1:0]];
                rep.slot_index      = k[3:0];
                rep.run_last        = (k + 1 == filled);
                rep.reservoir_empty = 1'b0;
                rep.total_seen      = seen_count;
                report_queue        = {report_queue, rep};
            end
            seen_count = '0;
        end
    endtask

    function automatic int field_mismatch(input string name, input logic [31:0] exp_v,
                                          input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s: expected 0x%08h, got 0x%08h", name, exp_v, act_v);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        rs_out_t want;
        int      bad;
        if (!rst_n)
        begin
            seen_count = '0;
            size_reg   = SIZE_RESET;
            report_queue.delete();
            errors     = 0;
        end
        else
        begin
            bad = 0;
            if (result_valid && result_ready)
            begin
                if (report_queue.size() == 0)
                begin
                    $error("result transaction with no report pending: 0x%h", result);
                    bad++;
                end
                else
                begin
                    want = report_queue.pop_front();
                    bad += field_mismatch("sample_value", want.sample_value,
                                          result.sample_value);
                    bad += field_mismatch("slot_index", 32'(want.slot_index),
                                          32'(result.slot_index));
                    bad += field_mismatch("run_last", 32'(want.run_last), 32'(result.run_last));
                    bad += field_mismatch("reservoir_empty", 32'(want.reservoir_empty),
                                          32'(result.reservoir_empty));
                    bad += field_mismatch("total_seen", want.total_seen, result.total_seen);
                end
            end
            if (cfg_we)
                size_reg = cfg_wdata;
            if (item_valid && item_ready)
                sample_or_flush(item);
            errors += bad;
        end
        fail_count <= errors;
        pending    <= report_queue.size();
    end

endmodule

[sim/reservoir_sampler_tb.sv]
`timescale 1ns / 1ps
// Top of the reservoir sampler testbench: clock, reset, stimulus and the verdict.
// Depends on rs_pkg, the reservoir_sampler block and reservoir_sampler_checker.
module reservoir_sampler_tb;
    import rs_pkg::*;

    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              item_valid   = 1'b0;
    logic              item_ready;
    rs_in_t            item         = '0;
    logic              result_valid;
    logic              result_ready = 1'b0;
    rs_out_t           result;
    logic              cfg_we       = 1'b0;
    logic [SIZE_W-1:0] cfg_wdata    = '0;
    int                fail_count;
    int                pending;
    int                ready_cnt    = 0;
    int                sent         = 0;
    int                run_len      = 0;
    logic [SIZE_W-1:0] size_now     = SIZE_RESET;

    reservoir_sampler uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata)
    );

    reservoir_sampler_checker scoreboard (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic int gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(0, 2);
        if (r < 95)
            return $urandom_range(3, 8);
        return $urandom_range(20, 60);
    endfunction

    function automatic int unsigned slots_in_use(input logic [SIZE_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > DEPTH_DEFAULT)
            return DEPTH_DEFAULT;
        return 32'(v);
    endfunction

    // Growing the size is allowed only while every slot that a flush could report
    // has been written in the current run.
    function automatic bit size_ok(input logic [SIZE_W-1:0] v);
        return slots_in_use(v) <= slots_in_use(size_now) || run_len <= slots_in_use(size_now);
    endfunction

    function automatic logic [SIZE_W-1:0] pick_size();
        if ($urandom_range(0, 9) < 4)
            return SIZE_W'($urandom_range(0, 31));
        return SIZE_W'($urandom_range(1, 6));
    endfunction

    always @(posedge clk)
    begin
        if (ready_cnt > 0)
            ready_cnt <= ready_cnt - 1;
        else
        begin
            result_ready <= !result_ready;
            ready_cnt    <= result_ready ? gap_len() : 4 * gap_len();
        end
    end

    task automatic send(input logic act, input logic [31:0] value, input logic [31:0] rnd,
                        input int gap);
        rs_in_t t;
        t.action      = act;
        t.item_value  = value;
        t.random_word = rnd;
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= t;
        do
            @(posedge clk);
        while (!item_ready);
        sent++;
        if (act == ACT_FLUSH)
            run_len = 0;
        else
            run_len++;
    endtask

    task automatic settle();
        item_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_size(input logic [SIZE_W-1:0] v);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        size_now  = v;
    endtask

    initial
    begin
        int                len;
        bit                burst;
        bit                noisy;
        logic              act;
        logic [31:0]       rnd;
        logic [SIZE_W-1:0] v;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // An empty flush right after reset, then a short run at the reset size.
        send(ACT_FLUSH, 32'h0, 32'h0, 0);
        send(ACT_OFFER, 32'h7FFF_FFFF, 32'h0000_0000, 0);
        send(ACT_OFFER, 32'h8000_0000, 32'hFFFF_FFFF, 1);
        send(ACT_OFFER, 32'hFFFF_FFFF, 32'h1234_5678, 0);
        send(ACT_FLUSH, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);

        // A zero size acts as one slot; the later offers draw replacements.
        write_size(5'd0);
        send(ACT_OFFER, 32'h0000_0000, 32'h0000_0000, 0);
        send(ACT_OFFER, 32'h1111_1111, 32'h0000_0000, 0);
        send(ACT_OFFER, 32'h2222_2222, 32'hFFFF_FFFF, 2);
        send(ACT_OFFER, 32'h3333_3333, 32'h0000_0005, 0);
        send(ACT_FLUSH, 32'h0, 32'h0, 0);

        write_size(5'd2);
        send(ACT_OFFER, 32'hAAAA_AAAA, 32'h0, 0);
        send(ACT_OFFER, 32'h5555_5555, 32'h0, 0);
        send(ACT_OFFER, 32'hC0DE_0001, 32'h0000_0001, 0);
        send(ACT_OFFER, 32'hC0DE_0002, 32'hFFFF_FFFF, 0);
        send(ACT_FLUSH, 32'h0, 32'h0, 0);

        // An oversized setting saturates, then the size shrinks in the middle of a run.
        write_size(5'd31);
        send(ACT_OFFER, 32'h0000_0001, 32'h0, 0);
        send(ACT_OFFER, 32'h0000_0002, 32'h0, 0);
        send(ACT_OFFER, 32'h0000_0003, 32'h0, 0);
        write_size(5'd1);
        send(ACT_FLUSH, 32'h0, 32'h0, 0);
        send(ACT_FLUSH, 32'h0, 32'h0, 0);

        while (sent < 321)
        begin
            burst = ($urandom_range(0, 3) == 0);
            noisy = ($urandom_range(0, 6) == 0);
            if ($urandom_range(0, 2) == 0)
                write_size(pick_size());
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 12);
            for (int i = 0; i < len; i++)
            begin
                if ($urandom_range(0, 19) == 0)
                begin
                    v = pick_size();
                    if (size_ok(v))
                        write_size(v);
                end
                act = (noisy && $urandom_range(0, 3) == 0) ? ACT_FLUSH : ACT_OFFER;
                rnd = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 2 * run_len + 2);
                send(act, $urandom, rnd, burst ? 0 : gap_len());
            end
            if ($urandom_range(0, 5) == 0)
                settle();
            send(ACT_FLUSH, $urandom, $urandom, burst ? 0 : gap_len());
        end

        settle();
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
